>>> design/rlbd_pkg.sv
// Shared types, register indexes and constants for the ladder button debouncer.
`timescale 1ns / 1ps
`default_nettype none
package rlbd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int CFG_DATA_W      = 12;
    localparam int CFG_IDX_W       = 3;
    localparam int CODE_W          = 4;
    localparam int CNT_W           = 8;
    localparam int NUM_A_LEVELS    = 5;
    localparam int NUM_B_LEVELS    = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 3'd6;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] LEVEL_ONE_RST   = 12'd0;
    localparam logic [CFG_DATA_W-1:0] LEVEL_TWO_RST   = 12'd364;
    localparam logic [CFG_DATA_W-1:0] LEVEL_THREE_RST = 12'd1130;
    localparam logic [CFG_DATA_W-1:0] LEVEL_FOUR_RST  = 12'd2065;
    localparam logic [CFG_DATA_W-1:0] LEVEL_FIVE_RST  = 12'd2734;
    localparam logic [CFG_DATA_W-1:0] IDLE_LEVEL_RST  = 12'd4095;
    localparam logic [CNT_W-1:0]      DEBOUNCE_RST    = 8'd50;

    // Button codes
    localparam logic [CODE_W-1:0] CODE_NONE   = 4'd0;
    localparam logic [CODE_W-1:0] CODE_A_BASE = 4'd1;
    localparam logic [CODE_W-1:0] CODE_B_BASE = 4'd6;
    localparam logic [CODE_W-1:0] CODE_MAX    = 4'd9;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // Lane findings for one word, handed to the merge stage
    typedef struct packed {
        logic                    tick;
        logic                    idle_a;
        logic                    idle_b;
        logic [NUM_A_LEVELS-1:0] hit_a;
        logic [NUM_B_LEVELS-1:0] hit_b;
    } t_lane_hits;

endpackage
`default_nettype wire

>>> design/rlbd_match_lane.sv
// One compare lane: registered +-10% window test of a sample against a level.
`timescale 1ns / 1ps
`default_nettype none
module rlbd_match_lane #(
    parameter int SAMPLE_BITS = rlbd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SAMPLE_BITS-1:0] i_level,
    output logic                        o_hit
);

    localparam int PROD_W = SAMPLE_BITS + 4;

    logic [PROD_W-1:0] s_ext;
    logic [PROD_W-1:0] l_ext;
    logic [PROD_W-1:0] s_x10;
    logic [PROD_W-1:0] l_x9;
    logic [PROD_W-1:0] l_x11;
    logic              n_hit;
    logic              r_hit;

    // Constant multiplies as shift-add
    assign s_ext = PROD_W'(i_sample);
    assign l_ext = PROD_W'(i_level);
    assign s_x10 = (s_ext << 3) + (s_ext << 1);
    assign l_x9  = (l_ext << 3) + l_ext;
    assign l_x11 = (l_ext << 3) + (l_ext << 1) + l_ext;
    assign n_hit = (l_x9 <= s_x10) && (s_x10 <= l_x11);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule
`default_nettype wire

>>> design/rlbd_merge.sv
// Merge stage: priority-encode the lane hits into a button code.
`timescale 1ns / 1ps
`default_nettype none
module rlbd_merge (
    input  wire rlbd_pkg::t_lane_hits          i_hits,
    output logic [rlbd_pkg::CODE_W-1:0]        o_code
);

    always_comb begin
        o_code = rlbd_pkg::CODE_NONE;
        // Walk from the lowest priority up so the highest one wins
        for (int i = rlbd_pkg::NUM_B_LEVELS - 1; i >= 0; i--) begin
            if (i_hits.hit_b[i]) begin
                o_code = rlbd_pkg::CODE_B_BASE + rlbd_pkg::CODE_W'(i);
            end
        end
        for (int i = rlbd_pkg::NUM_A_LEVELS - 1; i >= 0; i--) begin
            if (i_hits.hit_a[i]) begin
                o_code = rlbd_pkg::CODE_A_BASE + rlbd_pkg::CODE_W'(i);
            end
        end
        if (i_hits.idle_a && i_hits.idle_b) begin
            o_code = rlbd_pkg::CODE_NONE;
        end
    end

endmodule
`default_nettype wire

>>> design/rlbd_debounce.sv
// Debounce state: candidate code, stable tick count and reported code.
`timescale 1ns / 1ps
`default_nettype none
module rlbd_debounce (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [rlbd_pkg::CODE_W-1:0]   i_code,
    input  wire logic                          i_tick,
    input  wire logic [rlbd_pkg::CNT_W-1:0]    i_debounce_ms,
    output logic                               o_emit,
    output logic [rlbd_pkg::CODE_W-1:0]        o_code
);

    logic [rlbd_pkg::CODE_W-1:0] r_candidate;
    logic [rlbd_pkg::CODE_W-1:0] n_candidate;
    logic [rlbd_pkg::CNT_W-1:0]  r_count;
    logic [rlbd_pkg::CNT_W-1:0]  n_count;
    logic [rlbd_pkg::CODE_W-1:0] r_reported;
    logic [rlbd_pkg::CODE_W-1:0] n_reported;

    always_comb begin
        n_candidate = r_candidate;
        n_count     = r_count;
        n_reported  = r_reported;
        if (i_code == rlbd_pkg::CODE_NONE || i_code != r_candidate) begin
            // Restart on any change; drop the report at once
            n_candidate = i_code;
            n_count     = '0;
            n_reported  = rlbd_pkg::CODE_NONE;
        end else begin
            if (i_tick && r_count != rlbd_pkg::CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (n_count > i_debounce_ms) begin
                n_reported = i_code;
            end
        end
    end

    assign o_emit = i_valid && (n_reported != r_reported);
    assign o_code = n_reported;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate <= rlbd_pkg::CODE_NONE;
            r_count     <= '0;
            r_reported  <= rlbd_pkg::CODE_NONE;
        end else if (i_valid) begin
            r_candidate <= n_candidate;
            r_count     <= n_count;
            r_reported  <= n_reported;
        end
    end

    a_report_matches_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reported != rlbd_pkg::CODE_NONE |-> r_reported == r_candidate)
        else $error("reported code differs from candidate");

    a_reported_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reported <= rlbd_pkg::CODE_MAX)
        else $error("reported code out of range");

    a_none_has_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_candidate == rlbd_pkg::CODE_NONE |-> r_count == '0)
        else $error("count running with no candidate");

    a_emit_changes_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_reported == $past(o_code))
        else $error("emitted code not kept as reported");

endmodule
`default_nettype wire

>>> design/resistor_ladder_button_debouncer_unit.sv
// Top level of the resistor-ladder button decoder with debounce.
// Path: an accepted input word is registered in the lane stage, then merged and debounced
//   into the output register; a word that changes no code gives none.
// Throughput: one input word per cycle while the output channel does not stall.
// Reset: synchronous, active low; clears levels to defaults, debounce state and valids.
// No clearing pass; the block takes words from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module resistor_ladder_button_debouncer_unit #(
    parameter int SAMPLE_BITS = rlbd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]            i_sample_a,
    input  wire logic [SAMPLE_BITS-1:0]            i_sample_b,
    input  wire logic                              i_ms_tick,
    // Output channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [rlbd_pkg::CODE_W-1:0]            o_button_code,
    // Configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rlbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rlbd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Level registers keep the low bits of the write data that fit the sample width
    localparam int KEEP_W = (SAMPLE_BITS < rlbd_pkg::CFG_DATA_W) ?
                            SAMPLE_BITS : rlbd_pkg::CFG_DATA_W;
    localparam int NUM_A  = rlbd_pkg::NUM_A_LEVELS;
    localparam int NUM_B  = rlbd_pkg::NUM_B_LEVELS;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0]       r_level [NUM_A];
    logic [SAMPLE_BITS-1:0]       r_idle_level;
    logic [rlbd_pkg::CNT_W-1:0]   r_debounce_ms;
    logic [SAMPLE_BITS-1:0]       cfg_level_val;
    logic                         cfg_write;

    assign o_cfg_ready   = 1'b1;
    assign cfg_write     = i_cfg_valid && o_cfg_ready;
    assign cfg_level_val = SAMPLE_BITS'(i_cfg_data[KEEP_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level[0]    <= SAMPLE_BITS'(rlbd_pkg::LEVEL_ONE_RST);
            r_level[1]    <= SAMPLE_BITS'(rlbd_pkg::LEVEL_TWO_RST);
            r_level[2]    <= SAMPLE_BITS'(rlbd_pkg::LEVEL_THREE_RST);
            r_level[3]    <= SAMPLE_BITS'(rlbd_pkg::LEVEL_FOUR_RST);
            r_level[4]    <= SAMPLE_BITS'(rlbd_pkg::LEVEL_FIVE_RST);
            r_idle_level  <= SAMPLE_BITS'(rlbd_pkg::IDLE_LEVEL_RST);
            r_debounce_ms <= rlbd_pkg::DEBOUNCE_RST;
        end else if (cfg_write) begin
            case (i_cfg_index)
                rlbd_pkg::REG_LEVEL_ONE:   r_level[0]    <= cfg_level_val;
                rlbd_pkg::REG_LEVEL_TWO:   r_level[1]    <= cfg_level_val;
                rlbd_pkg::REG_LEVEL_THREE: r_level[2]    <= cfg_level_val;
                rlbd_pkg::REG_LEVEL_FOUR:  r_level[3]    <= cfg_level_val;
                rlbd_pkg::REG_LEVEL_FIVE:  r_level[4]    <= cfg_level_val;
                rlbd_pkg::REG_IDLE_LEVEL:  r_idle_level  <= cfg_level_val;
                rlbd_pkg::REG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data[rlbd_pkg::CNT_W-1:0];
                default: begin
                    // Unused index: drop the write
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the lane stage advances whenever the output register
    // is empty or being emptied this cycle.
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic n_s1_valid;
    logic r_s1_tick;
    logic out_free;
    logic s1_advance;
    logic in_accept;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Tick travels with the lane results
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_tick <= i_ms_tick;
        end
    end

    // ---------------------------------------------------------------
    // Compare lanes: channel A against five levels plus idle,
    // channel B against four levels plus idle, all in parallel.
    // ---------------------------------------------------------------
    rlbd_pkg::t_lane_hits lane_hits;

    assign lane_hits.tick = r_s1_tick;

    for (genvar g = 0; g < NUM_A; g++) begin : g_lane_a
        rlbd_match_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_en     (in_accept),
            .i_sample (i_sample_a),
            .i_level  (r_level[g]),
            .o_hit    (lane_hits.hit_a[g])
        );
    end

    for (genvar g = 0; g < NUM_B; g++) begin : g_lane_b
        rlbd_match_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_en     (in_accept),
            .i_sample (i_sample_b),
            .i_level  (r_level[g]),
            .o_hit    (lane_hits.hit_b[g])
        );
    end

    rlbd_match_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_idle_a (
        .i_clk    (i_clk),
        .i_en     (in_accept),
        .i_sample (i_sample_a),
        .i_level  (r_idle_level),
        .o_hit    (lane_hits.idle_a)
    );

    rlbd_match_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_idle_b (
        .i_clk    (i_clk),
        .i_en     (in_accept),
        .i_sample (i_sample_b),
        .i_level  (r_idle_level),
        .o_hit    (lane_hits.idle_b)
    );

    // ---------------------------------------------------------------
    // Merge lanes into one code, then debounce
    // ---------------------------------------------------------------
    logic [rlbd_pkg::CODE_W-1:0] merged_code;
    logic                        deb_emit;
    logic [rlbd_pkg::CODE_W-1:0] deb_code;

    rlbd_merge u_merge (
        .i_hits (lane_hits),
        .o_code (merged_code)
    );

    rlbd_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_advance),
        .i_code        (merged_code),
        .i_tick        (lane_hits.tick),
        .i_debounce_ms (r_debounce_ms),
        .o_emit        (deb_emit),
        .o_code        (deb_code)
    );

    // ---------------------------------------------------------------
    // Output register: load a new word, or clear once the current one
    // is taken.
    // ---------------------------------------------------------------
    logic                        r_out_valid;
    logic [rlbd_pkg::CODE_W-1:0] r_out_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && deb_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && deb_emit) begin
            r_out_code <= deb_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_button_code = r_out_code;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && o_out_valid)
        else $error("input stalled with room in the pipeline");

    a_no_load_over_waiting_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !s1_advance)
        else $error("lane stage advanced over a waiting output word");

    a_held_lane_item_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_advance |=> r_s1_valid)
        else $error("lane item lost while held");

endmodule
`default_nettype wire

>>> verif/resistor_ladder_button_debouncer_unit_tb.sv
// Self-checking testbench for the ladder button debouncer: directed cases, then random traffic.
`timescale 1ns / 1ps
module resistor_ladder_button_debouncer_unit_tb;

    localparam int            SB            = rlbd_pkg::SAMPLE_BITS_DEF;
    localparam logic [SB-1:0] SAMPLE_MAX    = '1;
    localparam int            SETTLE_CYCLES = 8;       // margin for the lane stage and output register to empty
    localparam int            CYCLE_LIMIT   = 400000;
    localparam int            MAX_PRINTED   = 40;

    // Index 7 maps to no register; the block must drop writes to it
    localparam logic [rlbd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum int {PICK_IDLE, PICK_A, PICK_B, PICK_NOISE} t_pick;

    // Block ports, all inputs known from time zero
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    logic [SB-1:0]                   i_sample_a  = '0;
    logic [SB-1:0]                   i_sample_b  = '0;
    logic                            i_ms_tick   = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [rlbd_pkg::CODE_W-1:0]     o_button_code;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rlbd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rlbd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shadow of the ladder configuration and the debounce state
    int unsigned                     ladder_lvl [rlbd_pkg::NUM_A_LEVELS + 1];
    logic [rlbd_pkg::CNT_W-1:0]      deb_ticks;
    logic [rlbd_pkg::CODE_W-1:0]     cand_code;
    logic [rlbd_pkg::CNT_W-1:0]      stable_ticks;
    logic [rlbd_pkg::CODE_W-1:0]     shown_code;

    // Debounced codes the block still owes us, oldest first
    logic [rlbd_pkg::CODE_W-1:0]     awaited_codes [$];

    int                              mismatch_count = 0;
    int                              cycle_count    = 0;
    int                              send_idle_pct  = 0;
    int                              recv_idle_pct  = 0;

    resistor_ladder_button_debouncer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_ms_tick     (i_ms_tick),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_button_code (o_button_code),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Debounce predictor
    // ------------------------------------------------------------------

    // Exact +-10% window: 9*L <= 10*s <= 11*L
    function automatic bit near_level(input int unsigned s, input int unsigned lv);
        return (9 * lv <= 10 * s) && (10 * s <= 11 * lv);
    endfunction

    // Priority: both idle, then A levels one..five, then B levels one..four
    function automatic logic [rlbd_pkg::CODE_W-1:0] classify_pair(input logic [SB-1:0] a,
                                                                  input logic [SB-1:0] b);
        int i;
        if (near_level(a, ladder_lvl[rlbd_pkg::REG_IDLE_LEVEL]) &&
            near_level(b, ladder_lvl[rlbd_pkg::REG_IDLE_LEVEL]))
            return rlbd_pkg::CODE_NONE;
        for (i = 0; i < rlbd_pkg::NUM_A_LEVELS; i++)
            if (near_level(a, ladder_lvl[i]))
                return rlbd_pkg::CODE_A_BASE + rlbd_pkg::CODE_W'(i);
        for (i = 0; i < rlbd_pkg::NUM_B_LEVELS; i++)
            if (near_level(b, ladder_lvl[i]))
                return rlbd_pkg::CODE_B_BASE + rlbd_pkg::CODE_W'(i);
        return rlbd_pkg::CODE_NONE;
    endfunction

    // Advance the shadow state by one accepted word; queue the code it emits, if any
    function automatic void debounce_step(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                          input logic tick);
        logic [rlbd_pkg::CODE_W-1:0] code;
        logic [rlbd_pkg::CODE_W-1:0] nxt;
        code = classify_pair(a, b);
        nxt  = shown_code;
        if (code == rlbd_pkg::CODE_NONE || code != cand_code) begin
            // a new button (or none) restarts the count and drops the report at once
            cand_code    = code;
            stable_ticks = '0;
            nxt          = rlbd_pkg::CODE_NONE;
        end else begin
            if (tick && stable_ticks != rlbd_pkg::CNT_MAX)
                stable_ticks = stable_ticks + 1'b1;
            if (stable_ticks > deb_ticks)
                nxt = code;
        end
        if (nxt != shown_code) begin
            shown_code = nxt;
            awaited_codes.push_back(nxt);
        end
    endfunction

    function automatic void apply_reg(input logic [rlbd_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [rlbd_pkg::CFG_DATA_W-1:0] data);
        if (idx <= rlbd_pkg::REG_IDLE_LEVEL)
            ladder_lvl[idx] = data;
        else if (idx == rlbd_pkg::REG_DEBOUNCE_MS)
            deb_ticks = data[rlbd_pkg::CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random sample inside the +-10% window of a level
    function automatic logic [SB-1:0] near_sample(input int unsigned lv);
        int unsigned lo;
        int unsigned hi;
        lo = (9 * lv + 9) / 10;
        hi = (11 * lv) / 10;
        if (hi > SAMPLE_MAX)
            hi = SAMPLE_MAX;
        return SB'($urandom_range(hi, lo));
    endfunction

    // Debounce word with junk in the bits above the 8-bit count
    function automatic logic [rlbd_pkg::CFG_DATA_W-1:0] debounce_word(input int ticks);
        return {(rlbd_pkg::CFG_DATA_W - rlbd_pkg::CNT_W)'($urandom),
                rlbd_pkg::CNT_W'(ticks)};
    endfunction

    function automatic void pick_for_code(input int c, output t_pick pick, output int k);
        if (c < rlbd_pkg::CODE_A_BASE) begin
            pick = PICK_IDLE;
            k    = 0;
        end else if (c < rlbd_pkg::CODE_B_BASE) begin
            pick = PICK_A;
            k    = c - rlbd_pkg::CODE_A_BASE;
        end else begin
            pick = PICK_B;
            k    = c - rlbd_pkg::CODE_B_BASE;
        end
    endfunction

    // Build a sample pair aimed at one class; the predictor has the last word
    function automatic void make_pair(input t_pick pick, input int k,
                                      output logic [SB-1:0] a, output logic [SB-1:0] b);
        int tries;
        a = SB'($urandom_range(SAMPLE_MAX));
        b = SB'($urandom_range(SAMPLE_MAX));
        case (pick)
            PICK_IDLE: begin
                a = near_sample(ladder_lvl[rlbd_pkg::REG_IDLE_LEVEL]);
                b = near_sample(ladder_lvl[rlbd_pkg::REG_IDLE_LEVEL]);
            end
            PICK_A: begin
                a = near_sample(ladder_lvl[k]);
            end
            PICK_B: begin
                // keep channel A off its levels so the B level wins
                b = near_sample(ladder_lvl[k]);
                for (tries = 0;
                     tries < 8 &&
                     classify_pair(a, b) != rlbd_pkg::CODE_B_BASE + rlbd_pkg::CODE_W'(k);
                     tries++)
                    a = SB'($urandom_range(SAMPLE_MAX));
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one word; hold it until taken, then update the shadow state.
    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_word(input logic [SB-1:0] a, input logic [SB-1:0] b, input logic tick);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        i_ms_tick  <= tick;
        // decide at the falling edge, so the rising edge that follows takes the word
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        debounce_step(a, b, tick);
    endtask

    task automatic hold_button(input logic [SB-1:0] a, input logic [SB-1:0] b, input int n,
                               input int tick_pct);
        repeat (n) send_word(a, b, $urandom_range(99) < tick_pct);
    endtask

    // Drop valid, wait out every owed code, then let the pipeline empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_codes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rlbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rlbd_pkg::CFG_DATA_W-1:0] data);
        bit taken;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic load_ladder(input int unsigned l1, input int unsigned l2,
                               input int unsigned l3, input int unsigned l4,
                               input int unsigned l5, input int unsigned idle,
                               input logic [rlbd_pkg::CFG_DATA_W-1:0] deb_word);
        wait_drained();
        write_reg(rlbd_pkg::REG_LEVEL_ONE,   rlbd_pkg::CFG_DATA_W'(l1));
        write_reg(rlbd_pkg::REG_LEVEL_TWO,   rlbd_pkg::CFG_DATA_W'(l2));
        write_reg(rlbd_pkg::REG_LEVEL_THREE, rlbd_pkg::CFG_DATA_W'(l3));
        write_reg(rlbd_pkg::REG_LEVEL_FOUR,  rlbd_pkg::CFG_DATA_W'(l4));
        write_reg(rlbd_pkg::REG_LEVEL_FIVE,  rlbd_pkg::CFG_DATA_W'(l5));
        write_reg(rlbd_pkg::REG_IDLE_LEVEL,  rlbd_pkg::CFG_DATA_W'(idle));
        write_reg(rlbd_pkg::REG_DEBOUNCE_MS, deb_word);
    endtask

    task automatic set_debounce(input int ticks);
        wait_drained();
        write_reg(rlbd_pkg::REG_DEBOUNCE_MS, debounce_word(ticks));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset levels and the default 50-tick window: A level one sits at zero
    task automatic test_reset_defaults();
        hold_button('0, SAMPLE_MAX, 52, 100);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    endtask

    // A zero level matches only a zero sample
    task automatic test_level_zero();
        set_debounce(0);
        hold_button(SB'(1), SAMPLE_MAX, 2, 100);
        hold_button('0, '0, 2, 100);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    endtask

    // Samples just inside and just outside the +-10% window
    task automatic test_tolerance_edges();
        int unsigned band_ends [8] = '{899, 900, 1100, 1101, 327, 328, 400, 401};
        int i;
        wait_drained();
        write_reg(rlbd_pkg::REG_LEVEL_ONE, rlbd_pkg::CFG_DATA_W'(1000));
        for (i = 0; i < 8; i++)
            hold_button(SB'(band_ends[i]), SAMPLE_MAX, 2, 100);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    endtask

    // Walk every code; each change of button forces none first
    task automatic test_every_code();
        t_pick pick;
        int k;
        int c;
        logic [SB-1:0] a;
        logic [SB-1:0] b;
        set_debounce(0);
        for (c = rlbd_pkg::CODE_NONE; c <= rlbd_pkg::CODE_MAX; c++) begin
            pick_for_code(c, pick, k);
            make_pair(pick, k, a, b);
            hold_button(a, b, 2, 100);
        end
    endtask

    // New candidate's own tick is not counted, untick words add nothing,
    // a pending button holds the report, a switch drops it at once
    task automatic test_candidate_rules();
        logic [SB-1:0] a_two;
        logic [SB-1:0] a_three;
        set_debounce(1);
        a_two   = near_sample(ladder_lvl[rlbd_pkg::REG_LEVEL_TWO]);
        a_three = near_sample(ladder_lvl[rlbd_pkg::REG_LEVEL_THREE]);
        send_word(a_two, SAMPLE_MAX, 1'b1);
        send_word(a_two, SAMPLE_MAX, 1'b0);
        send_word(a_two, SAMPLE_MAX, 1'b1);
        send_word(a_two, SAMPLE_MAX, 1'b1);
        hold_button(a_three, SAMPLE_MAX, 3, 0);
        send_word(SB'(3300), SB'(3300), 1'b1);
    endtask

    // Levels at full scale; idle beats A, then an idle level of zero beats A level one
    task automatic test_ladder_extremes();
        set_debounce(0);
        write_reg(rlbd_pkg::REG_LEVEL_FIVE, rlbd_pkg::CFG_DATA_W'(SAMPLE_MAX));
        hold_button(SAMPLE_MAX, SAMPLE_MAX, 2, 100);
        hold_button(SAMPLE_MAX, '0, 2, 100);
        wait_drained();
        write_reg(rlbd_pkg::REG_IDLE_LEVEL, '0);
        write_reg(rlbd_pkg::REG_LEVEL_ONE, '0);
        hold_button('0, '0, 2, 100);
        hold_button('0, SAMPLE_MAX, 2, 100);
    endtask

    // A write to the unmapped index changes nothing
    task automatic test_ignored_index();
        wait_drained();
        write_reg(REG_UNMAPPED, '1);
        hold_button('0, SAMPLE_MAX, 3, 100);
        send_word(SB'(1), SB'(1), 1'b1);
    endtask

    // Count stops at 255: a 255 window never reports, 254 does
    task automatic test_count_saturation();
        load_ladder(rlbd_pkg::LEVEL_ONE_RST, rlbd_pkg::LEVEL_TWO_RST,
                    rlbd_pkg::LEVEL_THREE_RST, rlbd_pkg::LEVEL_FOUR_RST,
                    rlbd_pkg::LEVEL_FIVE_RST, rlbd_pkg::IDLE_LEVEL_RST, debounce_word(255));
        hold_button('0, SAMPLE_MAX, 300, 100);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        set_debounce(254);
        hold_button('0, SAMPLE_MAX, 258, 100);
        send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    endtask

    // Random ladder, then mostly runs of one button with random content, some noise
    task automatic test_random_traffic(input int n_items, input int deb_lo, input int deb_hi);
        int unsigned lv_one;
        int unsigned idle;
        int sent;
        int run_len;
        int i;
        int k;
        bit paused;
        t_pick pick;
        logic [SB-1:0] a;
        logic [SB-1:0] b;
        lv_one = ($urandom_range(3) == 0) ? 0 : $urandom_range(250);
        idle   = ($urandom_range(1) == 0) ? SAMPLE_MAX : $urandom_range(SAMPLE_MAX, 3500);
        load_ladder(lv_one, $urandom_range(500, 300), $urandom_range(1300, 900),
                    $urandom_range(2300, 1700), $urandom_range(3000, 2500), idle,
                    debounce_word($urandom_range(deb_hi, deb_lo)));
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            // hold off once midway until the block owes nothing
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(99) < 15) begin
                pick    = PICK_NOISE;
                k       = 0;
                run_len = 1;
            end else begin
                pick_for_code($urandom_range(rlbd_pkg::CODE_MAX), pick, k);
                run_len = $urandom_range(deb_ticks + 6, 1);
            end
            for (i = 0; i < run_len; i++) begin
                make_pair(pick, k, a, b);
                send_word(a, b, $urandom_range(99) < 80);
            end
            sent += run_len;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall, check each taken word against the oldest owed code
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_codes.size() == 0) begin
                report_mismatch($sformatf("button code %0d with none awaited", o_button_code));
            end else if (o_button_code !== awaited_codes[0]) begin
                report_mismatch($sformatf("button code %0d, awaited %0d",
                                          o_button_code, awaited_codes[0]));
                void'(awaited_codes.pop_front());
            end else begin
                void'(awaited_codes.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("resistor_ladder_button_debouncer_unit_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // mirror the reset state of the block
        ladder_lvl[rlbd_pkg::REG_LEVEL_ONE]   = rlbd_pkg::LEVEL_ONE_RST;
        ladder_lvl[rlbd_pkg::REG_LEVEL_TWO]   = rlbd_pkg::LEVEL_TWO_RST;
        ladder_lvl[rlbd_pkg::REG_LEVEL_THREE] = rlbd_pkg::LEVEL_THREE_RST;
        ladder_lvl[rlbd_pkg::REG_LEVEL_FOUR]  = rlbd_pkg::LEVEL_FOUR_RST;
        ladder_lvl[rlbd_pkg::REG_LEVEL_FIVE]  = rlbd_pkg::LEVEL_FIVE_RST;
        ladder_lvl[rlbd_pkg::REG_IDLE_LEVEL]  = rlbd_pkg::IDLE_LEVEL_RST;
        deb_ticks    = rlbd_pkg::DEBOUNCE_RST;
        cand_code    = rlbd_pkg::CODE_NONE;
        stable_ticks = '0;
        shown_code   = rlbd_pkg::CODE_NONE;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles now and then, receiver stalls often
        send_idle_pct = 32;
        recv_idle_pct = 69;
        test_reset_defaults();
        test_level_zero();
        test_tolerance_edges();
        test_every_code();
        test_candidate_rules();
        test_ladder_extremes();
        test_ignored_index();
        test_random_traffic(120, 0, 3);

        // swap: sender idles often, receiver rarely stalls
        send_idle_pct = 69;
        recv_idle_pct = 32;
        test_count_saturation();
        test_random_traffic(120, 0, 0);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120, 2, 8);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("resistor_ladder_button_debouncer_unit_tb: PASS");
        end else begin
            $display("resistor_ladder_button_debouncer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> resistor_ladder_button_debouncer_unit.f
design/rlbd_pkg.sv
design/rlbd_match_lane.sv
design/rlbd_merge.sv
design/rlbd_debounce.sv
design/resistor_ladder_button_debouncer_unit.sv
verif/resistor_ladder_button_debouncer_unit_tb.sv
